### hw/rtl/ndil_pkg.sv
// ndil_pkg: shared types and constants of the N-d index linearizer.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package ndil_pkg;

    localparam int NUM_DIMS       = 6;
    localparam int RANK_BITS      = 3;
    localparam int CFG_INDEX_BITS = 3;

    localparam int REG_RANK      = 0;
    localparam int REG_SIZE_BASE = 1;

    localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd4;

    typedef enum logic {
        OP_SPLIT = 1'b0,
        OP_FOLD  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_OVF   = 2'd2
    } status_t;

    // shape status handed from the shape registers to the datapath
    typedef struct packed {
        logic                busy;
        logic                total_big;
        logic                zero;
        logic [NUM_DIMS-1:0] active;
        logic [NUM_DIMS-1:0] stride_big;
    } shape_flags_t;

endpackage

`default_nettype wire

### hw/rtl/nd_index_linearizer_top.sv
// nd_index_linearizer_top: row-major offset <-> N-d coordinate converter.
// Stages: entry stage, one cell per coordinate bit, output register. Throughput one request
// per cycle while the skid slot is empty and the stride builder is idle.
// Reset is synchronous, active low: shape returns to rank 4, all sizes 1.
// After reset and after every config write the stride builder runs, one multiplier bit
// per cycle; s_ready stays low while it runs.
// Depends on ndil_pkg, ndil_shape, ndil_cell.
`default_nettype none

module nd_index_linearizer_top #(
    parameter int MAX_RANK    = 6,
    parameter int OFFSET_BITS = 48,
    parameter int DIM_BITS    = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ndil_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [DIM_BITS-1:0]                 cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic [OFFSET_BITS-1:0]              s_flat_offset,
    input  wire logic [DIM_BITS-1:0]                 s_in_coord0,
    input  wire logic [DIM_BITS-1:0]                 s_in_coord1,
    input  wire logic [DIM_BITS-1:0]                 s_in_coord2,
    input  wire logic [DIM_BITS-1:0]                 s_in_coord3,
    input  wire logic [DIM_BITS-1:0]                 s_in_coord4,
    input  wire logic [DIM_BITS-1:0]                 s_in_coord5,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [OFFSET_BITS-1:0]              m_flat_result,
    output logic      [DIM_BITS-1:0]                 m_out_coord0,
    output logic      [DIM_BITS-1:0]                 m_out_coord1,
    output logic      [DIM_BITS-1:0]                 m_out_coord2,
    output logic      [DIM_BITS-1:0]                 m_out_coord3,
    output logic      [DIM_BITS-1:0]                 m_out_coord4,
    output logic      [DIM_BITS-1:0]                 m_out_coord5,
    output ndil_pkg::status_t                        m_status
);
    import ndil_pkg::*;

    localparam int NCELL = NUM_DIMS * DIM_BITS;
    localparam int CW    = NUM_DIMS * DIM_BITS;

    logic [DIM_BITS-1:0]    size   [NUM_DIMS];
    logic [OFFSET_BITS-1:0] stride [NUM_DIMS];
    logic [OFFSET_BITS-1:0] total;
    shape_flags_t           flags;

    ndil_shape #(
        .MAX_RANK    (MAX_RANK),
        .OFFSET_BITS (OFFSET_BITS),
        .DIM_BITS    (DIM_BITS)
    ) u_shape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .size      (size),
        .stride    (stride),
        .total     (total),
        .flags     (flags)
    );

    // chain advances unless the skid slot is occupied
    logic en;
    logic accept;

    logic                   m_valid_reg;
    logic [OFFSET_BITS-1:0] m_flat_reg;
    logic [CW-1:0]          m_coords_reg;
    status_t                m_status_reg;
    logic                   skid_valid_reg;
    logic [OFFSET_BITS-1:0] skid_flat_reg;
    logic [CW-1:0]          skid_coords_reg;
    status_t                skid_status_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en && !flags.busy;
    assign accept  = s_valid && s_ready;

    // entry checks
    logic [CW-1:0]    in_coords;
    logic [CW-1:0]    ent_coords;
    logic [NUM_DIMS-1:0] coord_bad;
    status_t          ent_status;
    logic [OFFSET_BITS-1:0] ent_work;

    assign in_coords = {s_in_coord5, s_in_coord4, s_in_coord3,
                        s_in_coord2, s_in_coord1, s_in_coord0};

    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            coord_bad[d] = flags.active[d] && (in_coords[d*DIM_BITS +: DIM_BITS] >= size[d]);
        end
        if (s_opcode == OP_SPLIT) begin
            ent_work   = s_flat_offset;
            ent_coords = '0;
            ent_status = (flags.zero || (!flags.total_big && s_flat_offset >= total))
                       ? STAT_RANGE : STAT_OK;
        end else begin
            ent_work = '0;
            for (int d = 0; d < NUM_DIMS; d++) begin
                ent_coords[d*DIM_BITS +: DIM_BITS] = flags.active[d]
                    ? in_coords[d*DIM_BITS +: DIM_BITS] : '0;
            end
            ent_status = (|coord_bad) ? STAT_RANGE : STAT_OK;
        end
    end

    logic                   valid_c  [NCELL+1];
    opcode_t                op_c     [NCELL+1];
    status_t                status_c [NCELL+1];
    logic [OFFSET_BITS-1:0] work_c   [NCELL+1];
    logic [CW-1:0]          coords_c [NCELL+1];

    logic                   ent_valid_reg;
    opcode_t                ent_op_reg;
    status_t                ent_status_reg;
    logic [OFFSET_BITS-1:0] ent_work_reg;
    logic [CW-1:0]          ent_coords_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
        end else if (en) begin
            ent_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ent_op_reg     <= opcode_t'(s_opcode);
            ent_status_reg <= ent_status;
            ent_work_reg   <= ent_work;
            ent_coords_reg <= ent_coords;
        end
    end

    assign valid_c[0]  = ent_valid_reg;
    assign op_c[0]     = ent_op_reg;
    assign status_c[0] = ent_status_reg;
    assign work_c[0]   = ent_work_reg;
    assign coords_c[0] = ent_coords_reg;

    // major dimension first, msb of each coordinate first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        localparam int D_IDX = k / DIM_BITS;
        localparam int B_IDX = DIM_BITS - 1 - (k % DIM_BITS);
        ndil_cell #(
            .OFFSET_BITS (OFFSET_BITS),
            .DIM_BITS    (DIM_BITS),
            .DIM_IDX     (D_IDX),
            .BIT_IDX     (B_IDX)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .stride     (stride[D_IDX]),
            .stride_big (flags.stride_big[D_IDX]),
            .dim_active (flags.active[D_IDX]),
            .in_valid   (valid_c[k]),
            .in_op      (op_c[k]),
            .in_status  (status_c[k]),
            .in_work    (work_c[k]),
            .in_coords  (coords_c[k]),
            .out_valid  (valid_c[k+1]),
            .out_op     (op_c[k+1]),
            .out_status (status_c[k+1]),
            .out_work   (work_c[k+1]),
            .out_coords (coords_c[k+1])
        );
    end

    // result formatting: unused result fields and failed requests read zero
    logic                   push;
    logic [OFFSET_BITS-1:0] fmt_flat;
    logic [CW-1:0]          fmt_coords;
    status_t                fmt_status;

    always_comb begin
        fmt_status = status_c[NCELL];
        fmt_flat   = (op_c[NCELL] == OP_FOLD && fmt_status == STAT_OK) ? work_c[NCELL] : '0;
        fmt_coords = (op_c[NCELL] == OP_SPLIT && fmt_status == STAT_OK) ? coords_c[NCELL] : '0;
    end

    assign push = en && valid_c[NCELL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_flat_reg   <= skid_flat_reg;
                m_coords_reg <= skid_coords_reg;
                m_status_reg <= skid_status_reg;
            end else begin
                m_flat_reg   <= fmt_flat;
                m_coords_reg <= fmt_coords;
                m_status_reg <= fmt_status;
            end
        end else if (push) begin
            skid_flat_reg   <= fmt_flat;
            skid_coords_reg <= fmt_coords;
            skid_status_reg <= fmt_status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_flat_result = m_flat_reg;
    assign m_status      = m_status_reg;
    assign m_out_coord0  = m_coords_reg[0*DIM_BITS +: DIM_BITS];
    assign m_out_coord1  = m_coords_reg[1*DIM_BITS +: DIM_BITS];
    assign m_out_coord2  = m_coords_reg[2*DIM_BITS +: DIM_BITS];
    assign m_out_coord3  = m_coords_reg[3*DIM_BITS +: DIM_BITS];
    assign m_out_coord4  = m_coords_reg[4*DIM_BITS +: DIM_BITS];
    assign m_out_coord5  = m_coords_reg[5*DIM_BITS +: DIM_BITS];

    a_no_accept_while_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        flags.busy |-> !s_ready)
        else $error("request accepted while strides rebuild");

    a_cfg_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input open right after config write");

    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid slot full with output empty");

    a_fail_zero_flat : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STAT_OK) |-> (m_flat_reg == '0 && m_coords_reg == '0))
        else $error("failed request carries nonzero result");

endmodule

`default_nettype wire

### hw/rtl/ndil_shape.sv
// ndil_shape: shape configuration registers and a bit-serial stride builder.
// Depends on ndil_pkg.
`default_nettype none

module ndil_shape #(
    parameter int MAX_RANK    = 6,
    parameter int OFFSET_BITS = 48,
    parameter int DIM_BITS    = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ndil_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [DIM_BITS-1:0]                 cfg_wdata,
    output logic      [DIM_BITS-1:0]                 size    [ndil_pkg::NUM_DIMS],
    output logic      [OFFSET_BITS-1:0]              stride  [ndil_pkg::NUM_DIMS],
    output logic      [OFFSET_BITS-1:0]              total,
    output ndil_pkg::shape_flags_t                   flags
);
    import ndil_pkg::*;

    localparam int W   = OFFSET_BITS + DIM_BITS;
    localparam int LIM = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
    localparam int DW  = $clog2(NUM_DIMS);
    localparam int BW  = (DIM_BITS > 1) ? $clog2(DIM_BITS) : 1;

    logic [RANK_BITS-1:0]   rank_reg;
    logic [DIM_BITS-1:0]    size_reg   [NUM_DIMS];
    logic [OFFSET_BITS-1:0] stride_reg [NUM_DIMS];
    logic [NUM_DIMS-1:0]    sbig_reg;
    logic [OFFSET_BITS-1:0] total_reg;
    logic                   total_big_reg;
    logic                   busy_reg;
    logic [DW-1:0]          dim_reg;
    logic [BW-1:0]          bit_reg;
    logic [OFFSET_BITS-1:0] prod_reg;
    logic                   big_reg;
    logic [W-1:0]           acc_reg;

    logic [RANK_BITS:0]     rank_eff;
    logic [NUM_DIMS-1:0]    active;
    logic [NUM_DIMS-1:0]    size_zero;
    logic [DIM_BITS-1:0]    factor;
    logic [W-1:0]           addend;
    logic [W-1:0]           acc_next;
    logic                   big_next;
    logic                   last_bit;

    always_comb begin
        if (rank_reg == '0) begin
            rank_eff = (RANK_BITS+1)'(1);
        end else if ({1'b0, rank_reg} > (RANK_BITS+1)'(LIM)) begin
            rank_eff = (RANK_BITS+1)'(LIM);
        end else begin
            rank_eff = {1'b0, rank_reg};
        end
        for (int d = 0; d < NUM_DIMS; d++) begin
            active[d]    = (RANK_BITS+1)'(d) < rank_eff;
            size_zero[d] = size_reg[d] == '0;
        end
    end

    // one multiplier bit per cycle; unused dims multiply by one
    always_comb begin
        factor   = active[dim_reg] ? size_reg[dim_reg] : DIM_BITS'(1);
        addend   = factor[bit_reg] ? (W'(prod_reg) << bit_reg) : '0;
        acc_next = acc_reg + addend;
        big_next = big_reg | (|acc_next[W-1:OFFSET_BITS]);
        last_bit = bit_reg == BW'(DIM_BITS - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_RESET;
            for (int d = 0; d < NUM_DIMS; d++) begin
                size_reg[d] <= DIM_BITS'(1);
            end
            busy_reg <= 1'b1;
            dim_reg  <= DW'(NUM_DIMS - 1);
            bit_reg  <= '0;
            prod_reg <= OFFSET_BITS'(1);
            big_reg  <= 1'b0;
            acc_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_INDEX_BITS'(REG_RANK)) begin
                    rank_reg <= cfg_wdata[RANK_BITS-1:0];
                end
                for (int d = 0; d < NUM_DIMS; d++) begin
                    if (cfg_index == CFG_INDEX_BITS'(REG_SIZE_BASE + d)) begin
                        size_reg[d] <= cfg_wdata;
                    end
                end
                busy_reg <= 1'b1;
                dim_reg  <= DW'(NUM_DIMS - 1);
                bit_reg  <= '0;
                prod_reg <= OFFSET_BITS'(1);
                big_reg  <= 1'b0;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                if (bit_reg == '0) begin
                    stride_reg[dim_reg] <= prod_reg;
                    sbig_reg[dim_reg]   <= big_reg;
                end
                if (last_bit) begin
                    prod_reg <= acc_next[OFFSET_BITS-1:0];
                    big_reg  <= big_next;
                    acc_reg  <= '0;
                    bit_reg  <= '0;
                    if (dim_reg == '0) begin
                        total_reg     <= acc_next[OFFSET_BITS-1:0];
                        total_big_reg <= big_next;
                        busy_reg      <= 1'b0;
                    end else begin
                        dim_reg <= dim_reg - DW'(1);
                    end
                end else begin
                    acc_reg <= acc_next;
                    bit_reg <= bit_reg + BW'(1);
                end
            end
        end
    end

    assign size             = size_reg;
    assign stride           = stride_reg;
    assign total            = total_reg;
    assign flags.busy       = busy_reg;
    assign flags.total_big  = total_big_reg;
    assign flags.zero       = |(active & size_zero);
    assign flags.active     = active;
    assign flags.stride_big = sbig_reg;

endmodule

`default_nettype wire

### hw/rtl/ndil_cell.sv
// ndil_cell: one quotient / multiplier bit of one dimension.
// Split: restoring divide step by stride<<bit. Fold: conditional add of stride<<bit.
// Depends on ndil_pkg.
`default_nettype none

module ndil_cell #(
    parameter int OFFSET_BITS = 48,
    parameter int DIM_BITS    = 16,
    parameter int DIM_IDX     = 0,
    parameter int BIT_IDX     = 0
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    en,
    input  wire logic [OFFSET_BITS-1:0]                  stride,
    input  wire logic                                    stride_big,
    input  wire logic                                    dim_active,
    input  wire logic                                    in_valid,
    input  wire ndil_pkg::opcode_t                       in_op,
    input  wire ndil_pkg::status_t                       in_status,
    input  wire logic [OFFSET_BITS-1:0]                  in_work,
    input  wire logic [ndil_pkg::NUM_DIMS*DIM_BITS-1:0]  in_coords,
    output logic                                         out_valid,
    output ndil_pkg::opcode_t                            out_op,
    output ndil_pkg::status_t                            out_status,
    output logic      [OFFSET_BITS-1:0]                  out_work,
    output logic      [ndil_pkg::NUM_DIMS*DIM_BITS-1:0]  out_coords
);
    import ndil_pkg::*;

    localparam int W    = OFFSET_BITS + DIM_BITS;
    localparam int W1   = W + 1;
    localparam int CPOS = DIM_IDX * DIM_BITS + BIT_IDX;

    logic                            valid_reg;
    opcode_t                         op_reg;
    status_t                         status_reg;
    logic [OFFSET_BITS-1:0]          work_reg;
    logic [NUM_DIMS*DIM_BITS-1:0]    coords_reg;

    logic [W-1:0]                    div;
    logic [W-1:0]                    rem_ext;
    logic [W-1:0]                    diff;
    logic [W1-1:0]                   sum;
    logic                            take;
    status_t                         status_next;
    logic [OFFSET_BITS-1:0]          work_next;
    logic [NUM_DIMS*DIM_BITS-1:0]    coords_next;

    always_comb begin
        div         = W'(stride) << BIT_IDX;
        rem_ext     = W'(in_work);
        diff        = rem_ext - div;
        sum         = W1'(in_work) + W1'(div);
        take        = 1'b0;
        status_next = in_status;
        work_next   = in_work;
        coords_next = in_coords;
        if (in_op == OP_SPLIT) begin
            take = dim_active && !stride_big && (rem_ext >= div);
            coords_next[CPOS] = take;
            if (take) begin
                work_next = diff[OFFSET_BITS-1:0];
            end
        end else if (in_status == STAT_OK && dim_active && in_coords[CPOS]) begin
            // sticky overflow once the exact sum leaves the offset range
            if (stride_big || (|sum[W1-1:OFFSET_BITS])) begin
                status_next = STAT_OVF;
            end else begin
                work_next = sum[OFFSET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg     <= in_op;
            status_reg <= status_next;
            work_reg   <= work_next;
            coords_reg <= coords_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_op     = op_reg;
    assign out_status = status_reg;
    assign out_work   = work_reg;
    assign out_coords = coords_reg;

endmodule

`default_nettype wire

### tb/tb_nd_index_linearizer_top.sv
// Testbench for nd_index_linearizer_top: random and directed split/fold requests
// checked against a scoreboard that predicts every result. Depends on ndil_pkg.
`timescale 1ns / 100ps

module tb_nd_index_linearizer_top;
    import ndil_pkg::*;

    localparam int OFS_W = 48;
    localparam int DIM_W = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;
    localparam int UNUSED_REG = 7;

    typedef struct {
        opcode_t         op;
        logic [OFS_W-1:0] offset;
        logic [DIM_W-1:0] coord [NUM_DIMS];
    } request_t;

    typedef struct {
        logic [OFS_W-1:0] flat;
        logic [DIM_W-1:0] coord [NUM_DIMS];
        status_t          status;
    } conversion_t;

    class linearizer_board;
        logic [RANK_BITS-1:0] rank_reg;
        logic [DIM_W-1:0]     size_reg [NUM_DIMS];
        conversion_t          pending [$];
        int                   errors;

        function new();
            rank_reg = RANK_RESET;
            foreach (size_reg[d]) size_reg[d] = 1;
            errors = 0;
        endfunction

        function void write_reg(int idx, logic [DIM_W-1:0] v);
            if (idx == REG_RANK) rank_reg = v[RANK_BITS-1:0];
            else if (idx >= REG_SIZE_BASE && idx < REG_SIZE_BASE + NUM_DIMS)
                size_reg[idx - REG_SIZE_BASE] = v;
        endfunction

        function int rank_used();
            int r;
            r = rank_reg;
            if (r < 1) r = 1;
            if (r > NUM_DIMS) r = NUM_DIMS;
            return r;
        endfunction

        function void note_request(request_t rq);
            conversion_t e;
            logic [127:0] rest, acc, stride;
            int r;
            bit bad;
            r = rank_used();
            bad = 0;
            e.flat = '0;
            e.status = STAT_OK;
            foreach (e.coord[d]) e.coord[d] = '0;
            if (rq.op == OP_SPLIT) begin
                rest = rq.offset;
                for (int d = r - 1; d >= 0; d--) begin
                    if (size_reg[d] == 0) begin
                        bad = 1;
                        break;
                    end
                    e.coord[d] = DIM_W'(rest % size_reg[d]);
                    rest = rest / size_reg[d];
                end
                if (bad || rest != 0) begin
                    e.status = STAT_RANGE;
                    foreach (e.coord[d]) e.coord[d] = '0;
                end
            end else begin
                for (int d = 0; d < r; d++)
                    if (rq.coord[d] >= size_reg[d]) bad = 1;
                if (bad) begin
                    e.status = STAT_RANGE;
                end else begin
                    // exact sum; 96-bit stride times 16-bit coord fits in 128
                    acc = 0;
                    stride = 1;
                    for (int d = r - 1; d >= 0; d--) begin
                        acc += rq.coord[d] * stride;
                        stride *= size_reg[d];
                    end
                    if (acc >> OFS_W != 0) e.status = STAT_OVF;
                    else e.flat = acc[OFS_W-1:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(conversion_t got);
            conversion_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status expected %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.flat !== e.flat) begin
                $error("flat_result expected %0h got %0h", e.flat, got.flat);
                errors++;
            end
            foreach (e.coord[d])
                if (got.coord[d] !== e.coord[d]) begin
                    $error("out_coord%0d expected %0h got %0h", d, e.coord[d], got.coord[d]);
                    errors++;
                end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_opcode = 0;
    logic [OFS_W-1:0] s_flat_offset = '0;
    logic [DIM_W-1:0] s_in_coord [NUM_DIMS] = '{default: '0};
    logic m_valid;
    logic m_ready = 0;
    logic [OFS_W-1:0] m_flat_result;
    logic [DIM_W-1:0] m_out_coord [NUM_DIMS];
    status_t m_status;

    linearizer_board board = new();
    bit quiet = 0;
    int cycles = 0;
    int ready_hold = 0;

    always #1 aclk = ~aclk;

    nd_index_linearizer_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_flat_offset(s_flat_offset),
        .s_in_coord0(s_in_coord[0]), .s_in_coord1(s_in_coord[1]),
        .s_in_coord2(s_in_coord[2]), .s_in_coord3(s_in_coord[3]),
        .s_in_coord4(s_in_coord[4]), .s_in_coord5(s_in_coord[5]),
        .m_valid(m_valid), .m_ready(m_ready), .m_flat_result(m_flat_result),
        .m_out_coord0(m_out_coord[0]), .m_out_coord1(m_out_coord[1]),
        .m_out_coord2(m_out_coord[2]), .m_out_coord3(m_out_coord[3]),
        .m_out_coord4(m_out_coord[4]), .m_out_coord5(m_out_coord[5]),
        .m_status(m_status)
    );

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver side: random back-pressure
    always @(negedge aclk) begin
        if (aresetn && !quiet && ready_hold == 0 && $urandom_range(0, 99) < 25) begin
            ready_hold <= pick_gap();
            m_ready <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        conversion_t got;
        if (aresetn && m_valid && m_ready) begin
            got.flat = m_flat_result;
            got.status = m_status;
            foreach (got.coord[d]) got.coord[d] = m_out_coord[d];
            board.check_result(got);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with the request taken
    task automatic send(request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_opcode <= rq.op;
        s_flat_offset <= rq.offset;
        foreach (rq.coord[d]) s_in_coord[d] <= rq.coord[d];
        do @(posedge aclk); while (!s_ready);
        board.note_request(rq);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    // leaves the enable high; the caller drops it after the last write
    task automatic write_reg(int idx, logic [DIM_W-1:0] v);
        cfg_wr_en <= 1;
        cfg_index <= CFG_INDEX_BITS'(idx);
        cfg_wdata <= v;
        board.write_reg(idx, v);
        @(negedge aclk);
    endtask

    task automatic set_shape(int rk, logic [DIM_W-1:0] sz [NUM_DIMS]);
        drain();
        write_reg(REG_RANK, DIM_W'(rk));
        for (int d = 0; d < NUM_DIMS; d++) write_reg(REG_SIZE_BASE + d, sz[d]);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [127:0] shape_total();
        logic [127:0] t;
        t = 1;
        for (int d = 0; d < board.rank_used(); d++) t *= board.size_reg[d];
        return t;
    endfunction

    function automatic request_t make_split(logic [OFS_W-1:0] ofs);
        request_t rq;
        rq.op = OP_SPLIT;
        rq.offset = ofs;
        foreach (rq.coord[d]) rq.coord[d] = DIM_W'($urandom);
        return rq;
    endfunction

    function automatic request_t make_fold(int kind);
        request_t rq;
        logic [DIM_W-1:0] sz;
        rq.op = OP_FOLD;
        rq.offset = OFS_W'({$urandom, $urandom});
        foreach (rq.coord[d]) begin
            sz = board.size_reg[d];
            case (kind)
                0: rq.coord[d] = (sz == 0) ? '0 : DIM_W'($urandom_range(0, sz - DIM_W'(1)));
                1: rq.coord[d] = (sz == 0) ? '0 : sz - DIM_W'(1);
                default: rq.coord[d] = DIM_W'($urandom);
            endcase
        end
        return rq;
    endfunction

    function automatic request_t make_random_request();
        logic [127:0] tot;
        logic [63:0] raw;
        int r;
        r = $urandom_range(0, 99);
        tot = shape_total();
        raw = {$urandom, $urandom};
        if (r < 40)
            return make_split((tot == 0 || tot > 48'hFFFF_FFFF_FFFF)
                              ? raw[OFS_W-1:0] : OFS_W'(raw % tot));
        if (r < 50) return make_split(raw[OFS_W-1:0] >> $urandom_range(0, OFS_W - 1));
        if (r < 85) return make_fold(0);
        if (r < 92) return make_fold(1);
        return make_fold(2);
    endfunction

    initial begin
        logic [DIM_W-1:0] sz [NUM_DIMS];
        request_t rq;
        int n;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // reset shape: rank 4, all sizes 1
        send(make_split(0));
        send(make_split(1));
        send(make_split('1));
        send(make_fold(0));
        rq = make_fold(0);
        rq.coord[2] = 1;
        send(rq);
        rq.coord[2] = 0;
        rq.coord[5] = 16'hFFFF;
        send(rq);

        // largest shape: fold overflows, split of any offset fits
        sz = '{default: 16'hFFFF};
        set_shape(6, sz);
        send(make_fold(1));
        send(make_fold(0));
        send(make_split('1));
        send(make_split(48'h5555_AAAA_5555));
        // rank 0 acts as 1, unused coordinates ignored
        sz = '{16'd1000, 16'd3, 16'd5, 16'd7, 16'd9, 16'd11};
        set_shape(0, sz);
        send(make_split(999));
        send(make_split(1000));
        send(make_fold(2));
        send(make_fold(1));
        // rank 7 acts as 6
        set_shape(7, sz);
        send(make_split(48'd1000 * 3 * 5 * 7 * 9 * 11 - 1));
        send(make_split(48'd1000 * 3 * 5 * 7 * 9 * 11));
        send(make_fold(1));
        // a zero size empties the shape
        sz[3] = 0;
        set_shape(6, sz);
        send(make_split(0));
        send(make_fold(0));
        drain();
        write_reg(UNUSED_REG, 16'hFFFF);
        cfg_wr_en <= 0;

        n = 0;
        while (n < 1250) begin
            quiet = ($urandom_range(0, 4) == 0);
            for (int d = 0; d < NUM_DIMS; d++) begin
                case ($urandom_range(0, 19))
                    0: sz[d] = 0;
                    1: sz[d] = 1;
                    2: sz[d] = 16'hFFFF;
                    3, 4, 5: sz[d] = DIM_W'($urandom);
                    default: sz[d] = DIM_W'($urandom_range(1, 12));
                endcase
            end
            set_shape($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 6), sz);
            repeat ($urandom_range(10, 50)) begin
                send(make_random_request());
                n++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ndil_pkg.sv
hw/rtl/ndil_shape.sv
hw/rtl/ndil_cell.sv
hw/rtl/nd_index_linearizer_top.sv
tb/tb_nd_index_linearizer_top.sv
